### hw/rtl/texel_format_to_rgba8_top_macros.svh
// Assertion helpers for the checker file.
`ifndef TEXEL_FORMAT_TO_RGBA8_TOP_MACROS_SVH
`define TEXEL_FORMAT_TO_RGBA8_TOP_MACROS_SVH

// Overlapping implication, switched off while the reset expression is high.
`define TFR_ASSERT_IMPL(lbl, clk_sig, rst_sig, ante, cons, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while the reset expression is high.
`define TFR_ASSERT_NEXT(lbl, clk_sig, rst_sig, ante, cons, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/tfr_pkg.sv
package tfr_pkg;

  // Palette storage.
  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);

  // Source format codes held in the texel_format register.
  localparam logic [2:0] FMT_CI4      = 3'd0;
  localparam logic [2:0] FMT_CI8      = 3'd1;
  localparam logic [2:0] FMT_IA8      = 3'd2;
  localparam logic [2:0] FMT_IA16     = 3'd3;
  localparam logic [2:0] FMT_RGBA5551 = 3'd4;

  // Register indexes on the configuration port.
  localparam logic REG_TEXEL_FORMAT = 1'b0;
  localparam logic REG_PREMULTIPLY  = 1'b1;

  // Input word field positions.
  localparam int TEXEL_LSB = 0;
  localparam int ODD_LSB   = 16;
  localparam int PIDX_LSB  = 17;
  localparam int PCOL_LSB  = 25;

  // One output pixel, red in the lowest byte.
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  // Exact x*255/31 for a 5-bit channel.
  localparam logic [7:0] WIDEN5_LUT [32] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return WIDEN5_LUT[v];
  endfunction

endpackage

### hw/rtl/tfr_ram.sv
module tfr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port; read data holds when idle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/tfr_convert.sv
module tfr_convert (
  input  logic [2:0]      fmt,
  input  logic            premul,
  input  logic [15:0]     texel,
  input  logic [15:0]     pal_color,
  input  logic            pal_hit,
  output tfr_pkg::pixel_t pixel
);
  import tfr_pkg::*;

  logic [15:0] color;
  pixel_t      expanded;

  // Pick the RGBA5551 source: the texel itself, the palette entry, or zero on a palette miss.
  always_comb begin
    if (fmt == FMT_RGBA5551) begin
      color = texel;
    end else if (pal_hit) begin
      color = pal_color;
    end else begin
      color = '0;
    end
    expanded.red   = widen5(color[15:11]);
    expanded.green = widen5(color[10:6]);
    expanded.blue  = widen5(color[5:1]);
    expanded.alpha = color[0] ? 8'hFF : 8'h00;
  end

  // Format selection. Premultiply applies to RGBA5551 only, whose alpha is 0 or 255, so
  // premultiplying either clears the colour channels or leaves them unchanged.
  always_comb begin
    pixel = '0;
    case (fmt)
      FMT_CI4, FMT_CI8: begin
        pixel = expanded;
      end
      FMT_IA8: begin
        pixel.red   = {texel[7:4], texel[7:4]};
        pixel.green = {texel[7:4], texel[7:4]};
        pixel.blue  = {texel[7:4], texel[7:4]};
        pixel.alpha = {texel[3:0], texel[3:0]};
      end
      FMT_IA16: begin
        pixel.red   = texel[15:8];
        pixel.green = texel[15:8];
        pixel.blue  = texel[15:8];
        pixel.alpha = texel[7:0];
      end
      FMT_RGBA5551: begin
        pixel = expanded;
        if (premul && !color[0]) begin
          pixel.red   = '0;
          pixel.green = '0;
          pixel.blue  = '0;
        end
      end
      default: begin
        pixel = '0;
      end
    endcase
  end

endmodule

### hw/rtl/texel_format_to_rgba8_top.sv
// A convert word goes through the input register and palette read, then the result register.
// Throughput: one word per cycle unless the output stalls; the palette RAM read port and
// the output register each take one item per cycle, and a palette write gives no result.
// Reset: rst is synchronous and active high; it clears the configuration registers and the
// pipeline valid flags. Palette contents are undefined until written.
module texel_format_to_rgba8_top (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata: texel[15:0], odd_position[16], palette_index[24:17],
  // palette_color[40:25], zero[47:41]
  input  logic [47:0] s_tdata,
  // s_tuser: kind[0]
  input  logic        s_tuser,
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata: red[7:0], green[15:8], blue[23:16], alpha[31:24]
  output logic [31:0] m_tdata,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tfr_pkg::*;

  logic [2:0]        texel_format;
  logic              premultiply_enable;
  logic              advance;
  logic              accept;
  logic [15:0]       in_texel;
  logic              in_odd;
  logic [7:0]        in_pidx;
  logic [15:0]       in_pcol;
  logic [7:0]        rd_index;
  logic              rd_hit;
  logic              wr_hit;
  logic              pal_we;
  logic              pal_re;
  logic [15:0]       pal_rdata;
  logic              v1;
  logic [15:0]       texel1;
  logic              hit1;
  pixel_t            pixel;

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      texel_format       <= FMT_CI4;
      premultiply_enable <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_TEXEL_FORMAT: texel_format       <= pwdata[2:0];
        REG_PREMULTIPLY:  premultiply_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TEXEL_FORMAT: prdata = {29'd0, texel_format};
      REG_PREMULTIPLY:  prdata = {31'd0, premultiply_enable};
      default:          prdata = '0;
    endcase
  end

  // Handshake: the whole pipeline moves when the output register is free or being emptied.
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;
  assign accept   = s_tvalid && advance;

  assign in_texel = s_tdata[TEXEL_LSB +: 16];
  assign in_odd   = s_tdata[ODD_LSB];
  assign in_pidx  = s_tdata[PIDX_LSB +: 8];
  assign in_pcol  = s_tdata[PCOL_LSB +: 16];

  // Palette index for this word; CI4 picks a nibble by position.
  always_comb begin
    if (texel_format == FMT_CI4) begin
      rd_index = in_odd ? {4'd0, in_texel[3:0]} : {4'd0, in_texel[7:4]};
    end else begin
      rd_index = in_texel[7:0];
    end
  end

  assign rd_hit = {1'b0, rd_index} < 9'(PALETTE_DEPTH);
  assign wr_hit = {1'b0, in_pidx} < 9'(PALETTE_DEPTH);
  assign pal_we = accept && s_tuser && wr_hit;
  assign pal_re = accept && !s_tuser;

  tfr_ram #(
    .WIDTH(16),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk  (clk),
    .we   (pal_we),
    .waddr(in_pidx[PAL_AW-1:0]),
    .wdata(in_pcol),
    .re   (pal_re),
    .raddr(rd_index[PAL_AW-1:0]),
    .rdata(pal_rdata)
  );

  // Input register, aligned with the palette read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= accept && !s_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      texel1 <= in_texel;
      hit1   <= rd_hit;
    end
  end

  tfr_convert u_convert (
    .fmt      (texel_format),
    .premul   (premultiply_enable),
    .texel    (texel1),
    .pal_color(pal_rdata),
    .pal_hit  (hit1),
    .pixel    (pixel)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= pixel;
    end
  end

endmodule

### hw/rtl/tfr_checker.sv
`include "texel_format_to_rgba8_top_macros.svh"

module tfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // A stalled result word stays valid and unchanged.
  `TFR_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

  // Input is taken whenever the output register is free or being emptied.
  `TFR_ASSERT_IMPL(a_ready_follows_out, clk, 1'b0, 1'b1, s_tready === (!m_tvalid || m_tready), "s_tready does not track output")

  // The cycle after reset no result is offered.
  `TFR_ASSERT_IMPL(a_reset_empty, clk, 1'b0, $past(rst), !m_tvalid, "result valid right after reset")

  // A new result always comes from an accepted convert word via the input and result registers.
  `TFR_ASSERT_IMPL(a_result_source, clk, rst, $rose(m_tvalid), $past(s_tvalid && s_tready && !s_tuser, 2), "result without a convert word")

endmodule

bind texel_format_to_rgba8_top tfr_checker u_tfr_checker (.*);

### sim/texel_format_to_rgba8_top_tb.sv
module texel_format_to_rgba8_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tfr_pkg::*;

  // Word kinds carried on s_tuser.
  localparam logic KIND_CONVERT   = 1'b0;
  localparam logic KIND_PAL_WRITE = 1'b1;

  // Format codes the block does not define; each must give a zero pixel.
  localparam logic [2:0] FMT_SPARE_5 = 3'd5;
  localparam logic [2:0] FMT_SPARE_6 = 3'd6;
  localparam logic [2:0] FMT_SPARE_7 = 3'd7;

  localparam logic [2:0] FORMAT_SWEEP [8] = '{
    FMT_CI4, FMT_CI8, FMT_IA8, FMT_IA16, FMT_RGBA5551,
    FMT_SPARE_5, FMT_SPARE_6, FMT_SPARE_7
  };

  // Idling modes: none, sender idle, receiver stalling, both lightly.
  localparam int SEND_IDLE  [4] = '{0, 63, 0, 7};
  localparam int RECV_STALL [4] = '{0, 0, 63, 7};

  localparam int WORDS_PER_PHASE = 36;
  localparam int CYCLE_LIMIT     = 200000;

  typedef struct packed {
    logic        kind;
    logic [15:0] texel;
    logic        odd;
    logic [7:0]  pidx;
    logic [15:0] pcol;
  } in_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  texel_format_to_rgba8_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Words waiting to be sent, and pixels the block still owes.
  in_word_t pending_words [$];
  pixel_t   pixels_due [$];

  // Shadow of the block: configuration and palette as seen at acceptance.
  logic [2:0]  cfg_format = FMT_CI4;
  logic        cfg_premul = 1'b0;
  logic [15:0] shadow_palette [PALETTE_DEPTH];

  // Entries the stimulus has already loaded, so no unwritten entry is read.
  bit pal_loaded [PALETTE_DEPTH];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fault_count    = 0;
  int cycle_count    = 0;
  int words_in       = 0;
  int pal_writes_in  = 0;
  int pixels_checked = 0;
  int settings_used  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("texel_format_to_rgba8_top_tb: done, errors");
      $finish;
    end
  end

  // Exact x*255/31 widening of a 5-bit channel.
  function automatic logic [7:0] scale5(input logic [4:0] v);
    int unsigned p;
    p = 32'(v);
    p = (p * 255) / 31;
    return p[7:0];
  endfunction

  function automatic pixel_t expand_5551(input logic [15:0] c);
    pixel_t px;
    px.red   = scale5(c[15:11]);
    px.green = scale5(c[10:6]);
    px.blue  = scale5(c[5:1]);
    px.alpha = c[0] ? 8'hFF : 8'h00;
    return px;
  endfunction

  function automatic logic [7:0] premul_channel(input logic [7:0] c, input logic [7:0] a);
    int unsigned t;
    t = 32'(c);
    t = (t * 32'(a) + 127) / 255;
    return t[7:0];
  endfunction

  // Expected pixel for a convert word under the current shadow state.
  function automatic pixel_t predict_pixel(input logic [15:0] texel, input logic odd);
    pixel_t px;
    logic [7:0] lo;
    lo = texel[7:0];
    px = '0;
    case (cfg_format)
      FMT_CI4: begin
        px = expand_5551(shadow_palette[odd ? {4'h0, lo[3:0]} : {4'h0, lo[7:4]}]);
      end
      FMT_CI8: begin
        px = expand_5551(shadow_palette[lo]);
      end
      FMT_IA8: begin
        px.red   = 8'(lo[7:4]) * 8'd17;
        px.green = px.red;
        px.blue  = px.red;
        px.alpha = 8'(lo[3:0]) * 8'd17;
      end
      FMT_IA16: begin
        px.red   = texel[15:8];
        px.green = px.red;
        px.blue  = px.red;
        px.alpha = lo;
      end
      FMT_RGBA5551: begin
        px = expand_5551(texel);
        if (cfg_premul) begin
          px.red   = premul_channel(px.red, px.alpha);
          px.green = premul_channel(px.green, px.alpha);
          px.blue  = premul_channel(px.blue, px.alpha);
        end
      end
      default: begin
        px = '0;
      end
    endcase
    return px;
  endfunction

  // Driver: presents queued words, predicts each accepted convert word and mirrors each palette write.
  always @(posedge clk) begin
    in_word_t w;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        words_in <= words_in + 1;
        if (s_tuser == KIND_PAL_WRITE) begin
          shadow_palette[s_tdata[PIDX_LSB +: 8]] = s_tdata[PCOL_LSB +: 16];
          pal_writes_in <= pal_writes_in + 1;
        end else begin
          pixels_due.push_back(predict_pixel(s_tdata[TEXEL_LSB +: 16], s_tdata[ODD_LSB]));
        end
      end
      if (!s_tvalid || s_tready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          w = pending_words.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= w.kind;
          s_tdata  <= {7'b0, w.pcol, w.pidx, w.odd, w.texel};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted pixel against the oldest expectation.
  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pixels_due.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, got %h", $time, got);
        fault_count++;
      end else begin
        want = pixels_due.pop_front();
        pixels_checked++;
        if (got.red !== want.red) begin
          $display("%0t: red mismatch, expected %h, got %h", $time, want.red, got.red);
          fault_count++;
        end
        if (got.green !== want.green) begin
          $display("%0t: green mismatch, expected %h, got %h", $time, want.green, got.green);
          fault_count++;
        end
        if (got.blue !== want.blue) begin
          $display("%0t: blue mismatch, expected %h, got %h", $time, want.blue, got.blue);
          fault_count++;
        end
        if (got.alpha !== want.alpha) begin
          $display("%0t: alpha mismatch, expected %h, got %h", $time, want.alpha, got.alpha);
          fault_count++;
        end
      end
    end
  end

  // One APB transfer: setup cycle, access cycle, done when pready is high.
  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes a register, mirrors it in the shadow and reads it back.
  task automatic set_register(input logic idx, input logic [2:0] value);
    logic [2:0]  addr;
    logic [31:0] rd;
    logic [31:0] mask;
    addr = {idx, 2'b00};
    mask = (idx == REG_TEXEL_FORMAT) ? 32'h7 : 32'h1;
    apb_access(1'b1, addr, {29'b0, value} & mask, rd);
    if (idx == REG_TEXEL_FORMAT) begin
      cfg_format = value;
    end else begin
      cfg_premul = value[0];
    end
    apb_access(1'b0, addr, 32'h0, rd);
    if ((rd & mask) !== ({29'b0, value} & mask)) begin
      $display("%0t: register %0d readback, expected %h, got %h", $time, idx,
               {29'b0, value} & mask, rd & mask);
      fault_count++;
    end
  endtask

  task automatic apply_setting(input logic [2:0] fmt, input logic premul, input int mode);
    set_register(REG_TEXEL_FORMAT, fmt);
    set_register(REG_PREMULTIPLY, {2'b0, premul});
    send_idle_pct  = SEND_IDLE[mode];
    recv_stall_pct = RECV_STALL[mode];
    settings_used++;
  endtask

  // Waits until every word is accepted and every pixel has come back.
  task automatic drain();
    while (pending_words.size() != 0 || s_tvalid || pixels_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic void push_palette(input logic [7:0] idx, input logic [15:0] col);
    in_word_t w;
    w.kind  = KIND_PAL_WRITE;
    w.texel = 16'($urandom_range(16'hFFFF));
    w.odd   = 1'($urandom_range(1));
    w.pidx  = idx;
    w.pcol  = col;
    pal_loaded[idx] = 1'b1;
    pending_words.push_back(w);
  endfunction

  function automatic void push_convert(input logic [15:0] texel, input logic odd);
    in_word_t w;
    w.kind  = KIND_CONVERT;
    w.texel = texel;
    w.odd   = odd;
    w.pidx  = 8'($urandom_range(255));
    w.pcol  = 16'($urandom_range(16'hFFFF));
    pending_words.push_back(w);
  endfunction

  // Random words for one phase; a palette index is loaded before first use.
  function automatic void push_random(input logic [2:0] fmt, input int count);
    int r;
    logic [15:0] texel;
    logic [15:0] col;
    logic [7:0]  idx;
    logic        odd;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 15) begin
        idx = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 8'hFF : 8'h00)
                                       : 8'($urandom_range(255));
        col = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 16'hFFFF : 16'h0000)
                                       : 16'($urandom_range(16'hFFFF));
        push_palette(idx, col);
      end else begin
        r = $urandom_range(9);
        texel = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom_range(16'hFFFF));
        odd = 1'($urandom_range(1));
        if (fmt == FMT_CI4 || fmt == FMT_CI8) begin
          if (fmt == FMT_CI4) begin
            idx = odd ? {4'h0, texel[3:0]} : {4'h0, texel[7:4]};
          end else begin
            idx = texel[7:0];
          end
          if (!pal_loaded[idx]) begin
            push_palette(idx, 16'($urandom_range(16'hFFFF)));
          end
        end
        push_convert(texel, odd);
      end
    end
  endfunction

  initial begin
    logic premul;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: palette extremes and both CI4 nibble positions.
    apply_setting(FMT_CI4, 1'b0, 0);
    push_palette(8'h00, 16'hFFFF);
    push_palette(8'h0F, 16'h0001);
    push_palette(8'hFF, 16'hFFFE);
    push_convert(16'h00F0, 1'b0);
    push_convert(16'h00F0, 1'b1);
    push_convert(16'hFF0F, 1'b0);
    push_convert(16'h000F, 1'b1);
    drain();

    // CI8 at both index extremes, then an overwritten entry.
    apply_setting(FMT_CI8, 1'b1, 0);
    push_convert(16'h0000, 1'b0);
    push_convert(16'h00FF, 1'b0);
    push_palette(8'h00, 16'h0000);
    push_convert(16'hFF00, 1'b1);
    drain();

    apply_setting(FMT_IA8, 1'b1, 0);
    push_convert(16'h0000, 1'b0);
    push_convert(16'h00FF, 1'b1);
    push_convert(16'hAAF0, 1'b0);
    drain();

    apply_setting(FMT_IA16, 1'b0, 0);
    push_convert(16'h0000, 1'b0);
    push_convert(16'hFFFF, 1'b1);
    push_convert(16'h00FF, 1'b0);
    push_convert(16'hFF00, 1'b0);
    drain();

    // RGBA5551 with premultiply: opaque, transparent and single channels.
    apply_setting(FMT_RGBA5551, 1'b1, 0);
    push_convert(16'hFFFF, 1'b0);
    push_convert(16'hFFFE, 1'b0);
    push_convert(16'h0001, 1'b0);
    push_convert(16'hF801, 1'b1);
    drain();

    apply_setting(FMT_RGBA5551, 1'b0, 0);
    push_convert(16'hFFFE, 1'b0);
    push_convert(16'h07C1, 1'b1);
    drain();

    // Undefined format codes give a zero pixel.
    apply_setting(FMT_SPARE_5, 1'b1, 0);
    push_convert(16'hFFFF, 1'b1);
    drain();
    apply_setting(FMT_SPARE_7, 1'b0, 0);
    push_convert(16'hFFFF, 1'b0);
    drain();

    // Random phases: every format under every idling mode, premultiply alternating.
    for (int mode = 0; mode < 4; mode++) begin
      for (int f = 0; f < 8; f++) begin
        premul = 1'((f + mode) % 2);
        apply_setting(FORMAT_SWEEP[f], premul, mode);
        push_random(FORMAT_SWEEP[f], WORDS_PER_PHASE);
        drain();
      end
    end

    repeat (8) @(posedge clk);
    if (pixels_due.size() != 0) begin
      $display("%0t: %0d pixels expected but never seen, expected 0, got %0d", $time,
               pixels_due.size(), pixels_due.size());
      fault_count++;
    end

    $display("Sent %0d words (%0d palette loads) over %0d register settings.",
             words_in, pal_writes_in, settings_used);
    $display("Checked %0d pixels across all formats and idling modes; %0d faults.",
             pixels_checked, fault_count);
    if (fault_count == 0) begin
      $display("texel_format_to_rgba8_top_tb: done, clean");
    end else begin
      $display("texel_format_to_rgba8_top_tb: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/tfr_pkg.sv
hw/rtl/tfr_ram.sv
hw/rtl/tfr_convert.sv
hw/rtl/texel_format_to_rgba8_top.sv
hw/rtl/tfr_checker.sv
sim/texel_format_to_rgba8_top_tb.sv
